@@ hw/rtl/polygon_area_centroid_shoelace_assert.svh @@
// Assertion macros used by the checker file.
`ifndef POLYGON_AREA_CENTROID_SHOELACE_ASSERT_SVH
`define POLYGON_AREA_CENTROID_SHOELACE_ASSERT_SVH

// Clocked assertion, switched off while reset is held
`define PACS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pacs assertion failed");

// Clocked assertion that also covers the reset cycles
`define PACS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("pacs assertion failed");

`endif

@@ hw/rtl/pacs_pkg.sv @@
`default_nettype none
package pacs_pkg;

    // Field widths
    localparam int LON_W   = 32;
    localparam int LAT_W   = 31;
    localparam int COS_W   = 17;
    localparam int AREA_W  = 49;
    localparam int CENT_W  = 26;
    localparam int STAT_W  = 3;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 104;

    // Arithmetic widths
    localparam int ACC_W   = 128;
    localparam int PROD_W  = LON_W + LAT_W;
    localparam int CROSS_W = 64;
    localparam int FRAC_W  = 24;
    localparam int DIV_W   = ACC_W + FRAC_W;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int MUL_DIG = 8;
    localparam int MUL_STEPS = 64 / MUL_DIG;
    localparam int MCNT_W  = $clog2(MUL_STEPS);

    // Ring vertex counter saturates here
    localparam int MAX_RING_VERTICES = 4096;
    localparam int RCNT_W  = $clog2(MAX_RING_VERTICES + 1);
    localparam int MIN_RING_VERTICES = 4;

    // Scale factors: metres per 1e-7 degree, k*2^40 and k^2*2^53
    localparam logic [63:0] SCALE_K1 = 64'd12226028312;
    localparam logic [63:0] SCALE_K2 = 64'd1113681258800;
    localparam logic [63:0] COS_ONE  = 64'd65536;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
    localparam logic [CENT_W-1:0] CENT_MAX = CENT_W'(20100000);

    // Divide by three: (x * (2^49+1)/3) >> 49, exact for x below 2^48
    localparam logic [63:0] DIV3_MUL = 64'd187649984473771;
    localparam int          DIV3_SH  = 49;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_ZERO   = 3'd2,
        ST_NONPOS = 3'd3,
        ST_POLE   = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_MUL1, S_MUL2, S_CROSS, S_MUL, S_MX, S_MY, S_UPD,
        S_RING, S_FINAL, S_AREA1, S_AREA2, S_CX0, S_DIV, S_CX1, S_CX2, S_CX3,
        S_CX4, S_CX5, S_OUT
    } t_state;

    // One classified vertex
    typedef struct packed {
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
        logic [COS_W-1:0]        cos_ref;
        logic                    ring_end;
        logic                    poly_last;
    } t_item;

    // Vertex with its valid flag, front to queue and queue to back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_slot;

endpackage
`default_nettype wire

@@ hw/rtl/pacs_front.sv @@
`default_nettype none
module pacs_front (
    input  wire logic                      i_s_tvalid,
    input  wire logic [pacs_pkg::IN_W-1:0] i_s_tdata,
    input  wire logic                      i_s_tuser,
    input  wire logic                      i_s_tlast,
    output logic                           o_s_tready,
    input  wire logic                      i_q_full,
    output pacs_pkg::t_slot                o_push
);

    // Accept while the queue has room
    assign o_s_tready = !i_q_full;

    // Unpack and classify: polygon end also closes the ring
    always_comb begin
        o_push.valid          = i_s_tvalid && !i_q_full;
        o_push.item.lon       = i_s_tdata[31:0];
        o_push.item.lat       = i_s_tdata[62:32];
        o_push.item.cos_ref   = i_s_tdata[79:63];
        o_push.item.ring_end  = i_s_tuser || i_s_tlast;
        o_push.item.poly_last = i_s_tlast;
    end

endmodule
`default_nettype wire

@@ hw/rtl/pacs_queue.sv @@
`default_nettype none
module pacs_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire pacs_pkg::t_slot i_push,
    output logic           o_full,
    output pacs_pkg::t_slot o_head,
    input  wire logic      i_pop
);

    pacs_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_full      = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) r_wp <= !r_wp;
            if (i_pop)        r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push.valid) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/pacs_back.sv @@
`default_nettype none
module pacs_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire pacs_pkg::t_slot            i_head,
    output logic                            o_pop,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic [pacs_pkg::OUT_W-1:0]      o_out_data
);

    localparam int AW = pacs_pkg::ACC_W;
    localparam int DW = pacs_pkg::DIV_W;

    pacs_pkg::t_state r_state, n_state, r_ret, n_ret;

    // Current vertex and previous vertex
    pacs_pkg::t_item                       r_cur, n_cur;
    logic signed [pacs_pkg::LON_W-1:0]     r_prev_lon, n_prev_lon;
    logic signed [pacs_pkg::LAT_W-1:0]     r_prev_lat, n_prev_lat;
    logic [pacs_pkg::RCNT_W-1:0]           r_ring_cnt, n_ring_cnt;

    // Ring and polygon sums
    logic [AW-1:0] r_cross, n_cross, r_mx, n_mx, r_my, n_my;
    logic [AW-1:0] r_net, n_net, r_wx, n_wx, r_wy, n_wy;
    logic          r_hole, n_hole;
    pacs_pkg::t_status r_err, n_err;
    logic [pacs_pkg::COS_W-1:0] r_cos, n_cos;

    // Cross product terms
    logic signed [pacs_pkg::PROD_W-1:0]  r_p1, n_p1, r_p2, n_p2;
    logic signed [pacs_pkg::CROSS_W-1:0] r_r, n_r;

    // Serial multiplier
    logic [AW-1:0]                r_ma, n_ma, r_macc, n_macc;
    logic [63:0]                  r_mb, n_mb;
    logic [pacs_pkg::MCNT_W-1:0]  r_mcnt, n_mcnt;
    logic                         r_mneg, n_mneg;

    // Restoring divider
    logic [DW-1:0]                r_dn, n_dn, r_dq, n_dq;
    logic [AW-1:0]                r_dr, n_dr, r_dd, n_dd;
    logic [pacs_pkg::DCNT_W-1:0]  r_dcnt, n_dcnt;

    // Result fields
    logic [pacs_pkg::AREA_W-1:0]  r_area, n_area;
    logic [pacs_pkg::CENT_W-1:0]  r_cx, n_cx, r_cy, n_cy, r_sval, n_sval;
    pacs_pkg::t_status            r_stat, n_stat;
    logic                         r_axis, n_axis, r_cneg, n_cneg;
    logic                         r_ov, n_ov;
    logic [pacs_pkg::OUT_W-1:0]   r_od, n_od;

    // Datapath helpers
    logic signed [pacs_pkg::PROD_W-1:0]  w_sp;
    logic signed [pacs_pkg::CROSS_W-1:0] w_diff;
    logic signed [32:0] w_sum_x;
    logic signed [31:0] w_sum_y;
    logic [AW-1:0]      w_pp, w_mres, w_arnd, w_pc, w_w, w_wmag;
    logic [AW:0]        w_drs, w_drn;
    logic               w_dge;
    logic [63:0]        w_rmag;
    logic [56:0]        w_aval;
    logic [AW-1-pacs_pkg::DIV3_SH:0] w_q3;

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    // Shared 32x31 signed multiplier for the cross terms
    assign w_sp = (r_state == pacs_pkg::S_MUL1) ? (r_prev_lon * r_cur.lat)
                                                : (r_cur.lon * r_prev_lat);
    assign w_diff = {r_p1[pacs_pkg::PROD_W-1], r_p1} - {r_p2[pacs_pkg::PROD_W-1], r_p2};
    assign w_sum_x = {r_prev_lon[31], r_prev_lon} + {r_cur.lon[31], r_cur.lon};
    assign w_sum_y = {r_prev_lat[30], r_prev_lat} + {r_cur.lat[30], r_cur.lat};
    assign w_rmag  = r_r[63] ? 64'(-r_r) : 64'(r_r);

    // Multiplier digit step and signed result
    assign w_pp   = r_ma * {{(AW-pacs_pkg::MUL_DIG){1'b0}}, r_mb[pacs_pkg::MUL_DIG-1:0]};
    assign w_mres = r_mneg ? (~r_macc + 1'b1) : r_macc;

    // Divider bit step
    assign w_drs = {r_dr, r_dn[DW-1]};
    assign w_dge = (w_drs >= {1'b0, r_dd});
    assign w_drn = w_dge ? (w_drs - {1'b0, r_dd}) : w_drs;

    // Rounding for area and centroid scale
    assign w_arnd = w_mres + (AW'(1) << 70);
    assign w_aval = w_arnd[AW-1:71];
    assign w_pc   = w_mres + (AW'(3) << 79);
    assign w_w    = r_axis ? r_wy : r_wx;
    assign w_wmag = w_w[AW-1] ? (~w_w + 1'b1) : w_w;

    // Quotient by three from the reciprocal product
    assign w_q3   = w_mres[AW-1:pacs_pkg::DIV3_SH];

    // Sequencer
    always_comb begin
        n_state = r_state;  n_ret = r_ret;     n_cur = r_cur;
        n_prev_lon = r_prev_lon;  n_prev_lat = r_prev_lat;  n_ring_cnt = r_ring_cnt;
        n_cross = r_cross;  n_mx = r_mx;  n_my = r_my;
        n_net = r_net;  n_wx = r_wx;  n_wy = r_wy;
        n_hole = r_hole;  n_err = r_err;  n_cos = r_cos;
        n_p1 = r_p1;  n_p2 = r_p2;  n_r = r_r;
        n_ma = r_ma;  n_mb = r_mb;  n_macc = r_macc;  n_mcnt = r_mcnt;  n_mneg = r_mneg;
        n_dn = r_dn;  n_dq = r_dq;  n_dr = r_dr;  n_dd = r_dd;  n_dcnt = r_dcnt;
        n_area = r_area;  n_cx = r_cx;  n_cy = r_cy;  n_sval = r_sval;
        n_stat = r_stat;  n_axis = r_axis;  n_cneg = r_cneg;
        n_ov = r_ov && !i_out_ready;
        n_od = r_od;
        o_pop = 1'b0;

        unique case (r_state)
            pacs_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_cur   = i_head.item;
                    n_state = pacs_pkg::S_START;
                end
            end
            pacs_pkg::S_START: begin
                if (r_ring_cnt == '0 && !r_hole) n_cos = r_cur.cos_ref;
                n_state = (r_ring_cnt != '0) ? pacs_pkg::S_MUL1 : pacs_pkg::S_UPD;
            end
            pacs_pkg::S_MUL1: begin
                n_p1    = w_sp;
                n_state = pacs_pkg::S_MUL2;
            end
            pacs_pkg::S_MUL2: begin
                n_p2    = w_sp;
                n_state = pacs_pkg::S_CROSS;
            end
            pacs_pkg::S_CROSS: begin
                // cross sum, then east moment
                n_r     = w_diff;
                n_cross = r_cross + {{(AW-pacs_pkg::CROSS_W){w_diff[63]}}, w_diff};
                n_ma    = AW'($unsigned(w_sum_x[32] ? 33'(-w_sum_x) : 33'(w_sum_x)));
                n_mb    = w_diff[63] ? 64'(-w_diff) : 64'(w_diff);
                n_mneg  = w_sum_x[32] ^ w_diff[63];
                n_macc  = '0;
                n_mcnt  = '0;
                n_ret   = pacs_pkg::S_MX;
                n_state = pacs_pkg::S_MUL;
            end
            pacs_pkg::S_MUL: begin
                n_macc = r_macc + w_pp;
                n_ma   = r_ma << pacs_pkg::MUL_DIG;
                n_mb   = r_mb >> pacs_pkg::MUL_DIG;
                n_mcnt = r_mcnt + 1'b1;
                if (r_mcnt == pacs_pkg::MCNT_W'(pacs_pkg::MUL_STEPS - 1)) n_state = r_ret;
            end
            pacs_pkg::S_MX: begin
                n_mx    = r_mx + w_mres;
                n_ma    = AW'($unsigned(w_sum_y[31] ? 32'(-w_sum_y) : 32'(w_sum_y)));
                n_mb    = w_rmag;
                n_mneg  = w_sum_y[31] ^ r_r[63];
                n_macc  = '0;
                n_mcnt  = '0;
                n_ret   = pacs_pkg::S_MY;
                n_state = pacs_pkg::S_MUL;
            end
            pacs_pkg::S_MY: begin
                n_my    = r_my + w_mres;
                n_state = pacs_pkg::S_UPD;
            end
            pacs_pkg::S_UPD: begin
                n_prev_lon = r_cur.lon;
                n_prev_lat = r_cur.lat;
                if (r_ring_cnt < pacs_pkg::RCNT_W'(pacs_pkg::MAX_RING_VERTICES)) begin
                    n_ring_cnt = r_ring_cnt + 1'b1;
                end
                n_state = r_cur.ring_end ? pacs_pkg::S_RING : pacs_pkg::S_IDLE;
            end
            pacs_pkg::S_RING: begin
                // ring checks, then outer added or hole taken off
                if (r_ring_cnt < pacs_pkg::RCNT_W'(pacs_pkg::MIN_RING_VERTICES)) begin
                    if (r_err == pacs_pkg::ST_OK) n_err = pacs_pkg::ST_SHORT;
                end else if (r_cross == '0) begin
                    if (r_err == pacs_pkg::ST_OK) n_err = pacs_pkg::ST_ZERO;
                end else if (r_cross[AW-1] ^ r_hole) begin
                    n_net = r_net - r_cross;
                    n_wx  = r_wx - r_mx;
                    n_wy  = r_wy - r_my;
                end else begin
                    n_net = r_net + r_cross;
                    n_wx  = r_wx + r_mx;
                    n_wy  = r_wy + r_my;
                end
                n_cross    = '0;
                n_mx       = '0;
                n_my       = '0;
                n_ring_cnt = '0;
                n_hole     = 1'b1;
                n_state    = r_cur.poly_last ? pacs_pkg::S_FINAL : pacs_pkg::S_IDLE;
            end
            pacs_pkg::S_FINAL: begin
                n_area = '0;
                n_cx   = '0;
                n_cy   = '0;
                n_axis = 1'b0;
                if (r_cos == '0) begin
                    n_stat  = pacs_pkg::ST_POLE;
                    n_state = pacs_pkg::S_OUT;
                end else if (r_err != pacs_pkg::ST_OK) begin
                    n_stat  = r_err;
                    n_state = pacs_pkg::S_OUT;
                end else if (r_net[AW-1] || r_net == '0) begin
                    n_stat  = pacs_pkg::ST_NONPOS;
                    n_state = pacs_pkg::S_OUT;
                end else if (r_net[AW-1:64] != '0) begin
                    n_stat  = pacs_pkg::ST_OK;
                    n_area  = pacs_pkg::AREA_MAX;
                    n_state = pacs_pkg::S_CX0;
                end else begin
                    n_stat  = pacs_pkg::ST_OK;
                    n_ma    = {64'd0, r_net[63:0]};
                    n_mb    = 64'(r_cos);
                    n_mneg  = 1'b0;
                    n_macc  = '0;
                    n_mcnt  = '0;
                    n_ret   = pacs_pkg::S_AREA1;
                    n_state = pacs_pkg::S_MUL;
                end
            end
            pacs_pkg::S_AREA1: begin
                n_ma    = w_mres;
                n_mb    = pacs_pkg::SCALE_K2;
                n_macc  = '0;
                n_mcnt  = '0;
                n_ret   = pacs_pkg::S_AREA2;
                n_state = pacs_pkg::S_MUL;
            end
            pacs_pkg::S_AREA2: begin
                n_area  = (w_aval > 57'(pacs_pkg::AREA_MAX)) ? pacs_pkg::AREA_MAX
                                                             : w_aval[pacs_pkg::AREA_W-1:0];
                n_state = pacs_pkg::S_CX0;
            end
            pacs_pkg::S_CX0: begin
                // |W| * 2^24 / net
                n_cneg  = w_w[AW-1];
                n_dn    = {w_wmag, {pacs_pkg::FRAC_W{1'b0}}};
                n_dd    = r_net;
                n_dq    = '0;
                n_dr    = '0;
                n_dcnt  = '0;
                n_ret   = pacs_pkg::S_CX1;
                n_state = pacs_pkg::S_DIV;
            end
            pacs_pkg::S_DIV: begin
                n_dr   = w_drn[AW-1:0];
                n_dq   = {r_dq[DW-2:0], w_dge};
                n_dn   = r_dn << 1;
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == pacs_pkg::DCNT_W'(DW - 1)) n_state = r_ret;
            end
            pacs_pkg::S_CX1: begin
                if (r_dq[DW-1:59] != '0 || r_dq[58:57] == 2'b11) begin
                    n_sval  = pacs_pkg::CENT_MAX;
                    n_state = pacs_pkg::S_CX5;
                end else begin
                    n_ma    = AW'(r_dq[58:0]);
                    n_mb    = r_axis ? pacs_pkg::COS_ONE : 64'(r_cos);
                    n_mneg  = 1'b0;
                    n_macc  = '0;
                    n_mcnt  = '0;
                    n_ret   = pacs_pkg::S_CX2;
                    n_state = pacs_pkg::S_MUL;
                end
            end
            pacs_pkg::S_CX2: begin
                n_ma    = w_mres;
                n_mb    = pacs_pkg::SCALE_K1;
                n_macc  = '0;
                n_mcnt  = '0;
                n_ret   = pacs_pkg::S_CX3;
                n_state = pacs_pkg::S_MUL;
            end
            pacs_pkg::S_CX3: begin
                // rounded value over three by reciprocal multiply
                n_ma    = AW'(w_pc[AW-1:80]);
                n_mb    = pacs_pkg::DIV3_MUL;
                n_mneg  = 1'b0;
                n_macc  = '0;
                n_mcnt  = '0;
                n_ret   = pacs_pkg::S_CX4;
                n_state = pacs_pkg::S_MUL;
            end
            pacs_pkg::S_CX4: begin
                n_sval  = (w_q3 > {{(AW-pacs_pkg::DIV3_SH-pacs_pkg::CENT_W){1'b0}},
                                   pacs_pkg::CENT_MAX}) ? pacs_pkg::CENT_MAX
                                                        : w_q3[pacs_pkg::CENT_W-1:0];
                n_state = pacs_pkg::S_CX5;
            end
            pacs_pkg::S_CX5: begin
                if (r_axis) begin
                    n_cy    = r_cneg ? (~r_sval + 1'b1) : r_sval;
                    n_state = pacs_pkg::S_OUT;
                end else begin
                    n_cx    = r_cneg ? (~r_sval + 1'b1) : r_sval;
                    n_axis  = 1'b1;
                    n_state = pacs_pkg::S_CX0;
                end
            end
            pacs_pkg::S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_od    = {r_stat, r_cy, r_cx, r_area};
                    n_net   = '0;
                    n_wx    = '0;
                    n_wy    = '0;
                    n_hole  = 1'b0;
                    n_err   = pacs_pkg::ST_OK;
                    n_state = pacs_pkg::S_IDLE;
                end
            end
            default: n_state = pacs_pkg::S_IDLE;
        endcase
    end

    // Control and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pacs_pkg::S_IDLE;
            r_prev_lon <= '0;
            r_prev_lat <= '0;
            r_ring_cnt <= '0;
            r_cross    <= '0;
            r_mx       <= '0;
            r_my       <= '0;
            r_net      <= '0;
            r_wx       <= '0;
            r_wy       <= '0;
            r_hole     <= 1'b0;
            r_err      <= pacs_pkg::ST_OK;
            r_cos      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prev_lon <= n_prev_lon;
            r_prev_lat <= n_prev_lat;
            r_ring_cnt <= n_ring_cnt;
            r_cross    <= n_cross;
            r_mx       <= n_mx;
            r_my       <= n_my;
            r_net      <= n_net;
            r_wx       <= n_wx;
            r_wy       <= n_wy;
            r_hole     <= n_hole;
            r_err      <= n_err;
            r_cos      <= n_cos;
            r_ov       <= n_ov;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;   r_cur  <= n_cur;
        r_p1   <= n_p1;    r_p2   <= n_p2;   r_r    <= n_r;
        r_ma   <= n_ma;    r_mb   <= n_mb;   r_macc <= n_macc;
        r_mcnt <= n_mcnt;  r_mneg <= n_mneg;
        r_dn   <= n_dn;    r_dq   <= n_dq;   r_dr   <= n_dr;
        r_dd   <= n_dd;    r_dcnt <= n_dcnt;
        r_area <= n_area;  r_cx   <= n_cx;   r_cy   <= n_cy;
        r_sval <= n_sval;  r_stat <= n_stat;
        r_axis <= n_axis;  r_cneg <= n_cneg;
        r_od   <= n_od;
    end

endmodule
`default_nettype wire

@@ hw/rtl/polygon_area_centroid_shoelace.sv @@
// Per vertex: the first vertex of a ring needs no multiply; every later vertex takes two cross
//   multiplies and two 8-step serial moment multiplies, and a ring end adds the ring check.
// Polygon end adds one 152-step division per centroid axis on the bit-serial divider and up to
//   eight 8-step serial multiplies; the result is then held in an output register. A two-entry
//   queue takes vertices while the back end works.
// Reset (i_rst_n low, synchronous) empties the queue and zeroes all sums.
`default_nettype none
module polygon_area_centroid_shoelace (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [pacs_pkg::IN_W-1:0]  i_s_tdata,  // lon[31:0], lat[62:32], cos_ref[79:63]
    input  wire logic                       i_s_tuser,  // ring_last
    input  wire logic                       i_s_tlast,  // polygon_last
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [pacs_pkg::OUT_W-1:0]      o_m_tdata   // area_m2[48:0], centroid_x_m[74:49],
                                                        // centroid_y_m[100:75], status[103:101]
);

    pacs_pkg::t_slot w_push, w_head;
    logic            w_full, w_pop;

    // Accept and classify
    pacs_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    // Vertex queue
    pacs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // Accumulate and scale
    pacs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );

endmodule
`default_nettype wire

@@ hw/rtl/pacs_checker.sv @@
`default_nettype none
`include "polygon_area_centroid_shoelace_assert.svh"
module pacs_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_m_tvalid,
    input wire logic                       i_m_tready,
    input wire logic [pacs_pkg::OUT_W-1:0] o_m_tdata
);

    // Result held until taken
    `PACS_ASSERT_RST(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid)

    // Status is a known code
    `PACS_ASSERT_RST(a_stat_range, o_m_tvalid |-> o_m_tdata[103:101] <= pacs_pkg::ST_POLE)

    // A failed polygon carries zero area and centroid
    `PACS_ASSERT_RST(a_err_zero, o_m_tvalid && o_m_tdata[103:101] != pacs_pkg::ST_OK |->
        o_m_tdata[100:0] == 101'd0)

    // Nothing leaves straight after reset
    `PACS_ASSERT(a_rst_quiet, !i_rst_n |=> !o_m_tvalid)

endmodule

bind polygon_area_centroid_shoelace pacs_checker u_pacs_checker (.*);
`default_nettype wire

@@ bench/polygon_area_centroid_shoelace_test.sv @@
`default_nettype none
module polygon_area_centroid_shoelace_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pacs_pkg::*;

    // One vertex as it travels on the slave side
    typedef struct {
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
        logic [COS_W-1:0]        cos_ref;
        bit                      ring_last;
        bit                      poly_last;
    } t_vertex;

    // One polygon summary as it travels on the master side
    typedef struct {
        logic [AREA_W-1:0]        area;
        logic signed [CENT_W-1:0] cent_x;
        logic signed [CENT_W-1:0] cent_y;
        t_status                  status;
    } t_summary;

    // Stimulus row; a typed summary overrides the computed one
    typedef struct {
        t_vertex  v;
        bit       typed;
        t_summary want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [IN_W-1:0]     i_s_tdata = '0;
    logic                i_s_tuser = 1'b0;
    logic                i_s_tlast = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [OUT_W-1:0]    o_m_tdata;

    polygon_area_centroid_shoelace DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // lon, lat, cos_ref
        .i_s_tuser  (i_s_tuser),   // ring_last
        .i_s_tlast  (i_s_tlast),   // polygon_last
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // area_m2, centroid_x_m, centroid_y_m, status
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_row     rows[$];
    t_summary summaries_due[$];
    int       errors = 0;
    int       vertices_sent = 0;
    int       polygons_done = 0;
    int       summaries_seen = 0;

    // Shadow state of the block
    logic signed [63:0] last_lon, last_lat;
    int unsigned        ring_len;
    logic [127:0]       ring_cross, ring_mx, ring_my;
    logic [127:0]       poly_area, poly_wx, poly_wy;
    bit                 in_holes;
    t_status            first_err;
    logic [COS_W-1:0]   cos_hold;

    task automatic clear_shadow();
        last_lon = '0;
        last_lat = '0;
        ring_len = 0;
        ring_cross = '0;
        ring_mx = '0;
        ring_my = '0;
        poly_area = '0;
        poly_wx = '0;
        poly_wy = '0;
        in_holes = 1'b0;
        first_err = ST_OK;
        cos_hold = '0;
    endtask

    // Ring close: check, strip orientation, add or subtract
    task automatic close_ring();
        logic [127:0] a, mx, my;
        bit           neg;
        if (ring_len < MIN_RING_VERTICES) begin
            if (first_err == ST_OK) first_err = ST_SHORT;
        end else if (ring_cross == '0) begin
            if (first_err == ST_OK) first_err = ST_ZERO;
        end else begin
            neg = ring_cross[127];
            a  = neg ? -ring_cross : ring_cross;
            mx = neg ? -ring_mx : ring_mx;
            my = neg ? -ring_my : ring_my;
            if (in_holes) begin
                a = -a;
                mx = -mx;
                my = -my;
            end
            poly_area += a;
            poly_wx += mx;
            poly_wy += my;
        end
        ring_cross = '0;
        ring_mx = '0;
        ring_my = '0;
        ring_len = 0;
        in_holes = 1'b1;
    endtask

    // Centroid axis in metres from a net moment and the net cross sum
    function automatic logic signed [CENT_W-1:0] centroid_metres(
        logic [127:0] w, logic [127:0] net, logic [63:0] cf);
        bit           neg;
        logic [127:0] mag, q, p;
        logic [151:0] qf;
        logic [63:0]  s;
        neg = w[127];
        mag = neg ? -w : w;
        q = mag / net;
        if (q >= (128'd3 << 33)) begin
            s = 64'(CENT_MAX);
        end else begin
            qf = {mag, 24'b0} / {24'b0, net};
            p = 128'(qf[63:0]) * 128'(cf);
            p = p * 128'(SCALE_K1);
            p = p + (128'd3 << 79);
            s = 64'(p >> 80) / 64'd3;
            if (s > 64'(CENT_MAX)) s = 64'(CENT_MAX);
        end
        return neg ? -CENT_W'(s) : CENT_W'(s);
    endfunction

    // Advance the shadow state by one vertex; summary on polygon end
    task automatic shoelace_step(input t_vertex v, output bit has, output t_summary res);
        logic signed [63:0] lon, lat, r;
        logic [127:0]       rw, p;
        lon = 64'(v.lon);
        lat = 64'(v.lat);
        has = 1'b0;
        res = '{default: '0, status: ST_OK};
        if (ring_len == 0 && !in_holes) cos_hold = v.cos_ref;
        if (ring_len > 0) begin
            r = last_lon * lat - lon * last_lat;
            rw = 128'(r);
            ring_cross += rw;
            ring_mx += 128'(last_lon + lon) * rw;
            ring_my += 128'(last_lat + lat) * rw;
        end
        last_lon = lon;
        last_lat = lat;
        if (ring_len < MAX_RING_VERTICES) ring_len++;
        if (v.ring_last || v.poly_last) close_ring();
        if (!v.poly_last) return;
        has = 1'b1;
        if (cos_hold == '0) res.status = ST_POLE;
        else if (first_err != ST_OK) res.status = first_err;
        else if (poly_area[127] || poly_area == '0) res.status = ST_NONPOS;
        else begin
            if (poly_area[127:64] != '0) begin
                res.area = AREA_MAX;
            end else begin
                p = 128'(poly_area[63:0]) * 128'(cos_hold);
                p = p * 128'(SCALE_K2);
                p = (p + (128'd1 << 70)) >> 71;
                res.area = (p > 128'(AREA_MAX)) ? AREA_MAX : p[AREA_W-1:0];
            end
            res.cent_x = centroid_metres(poly_wx, poly_area, 64'(cos_hold));
            res.cent_y = centroid_metres(poly_wy, poly_area, COS_ONE);
        end
        poly_area = '0;
        poly_wx = '0;
        poly_wy = '0;
        in_holes = 1'b0;
        first_err = ST_OK;
    endtask

    task automatic add_row(input longint lon, input longint lat, input int cos_ref,
                           input bit rl, input bit pl);
        t_row r;
        r.v = '{lon: LON_W'(lon), lat: LAT_W'(lat), cos_ref: COS_W'(cos_ref),
                ring_last: rl, poly_last: pl};
        r.typed = 1'b0;
        r.want = '{default: '0, status: ST_OK};
        rows.push_back(r);
    endtask

    // Last vertex of an error polygon: all numeric fields zero
    task automatic add_error_row(input longint lon, input longint lat, input t_status st);
        add_row(lon, lat, 65536, 1'b1, 1'b1);
        rows[$].typed = 1'b1;
        rows[$].want.status = st;
    endtask

    // One ring of n random points around a centre, optionally closed
    task automatic add_ring(input longint clon, input longint clat, input int unsigned span,
                            input int n, input int cos_ref, input bit closed, input bit pl);
        longint lon0, lat0, lon, lat;
        int     total;
        total = closed ? n + 1 : n;
        for (int i = 0; i < total; i++) begin
            if (i == n) begin
                lon = lon0;
                lat = lat0;
            end else begin
                lon = clon + longint'($urandom_range(0, 2 * span)) - span;
                lat = clat + longint'($urandom_range(0, 2 * span)) - span;
            end
            if (i == 0) begin
                lon0 = lon;
                lat0 = lat;
            end
            add_row(lon, lat, cos_ref, i == total - 1, pl && (i == total - 1));
        end
    endtask

    // Random polygon: mostly well formed, some noise and broken rings
    task automatic add_random_polygon();
        int          kind, holes, cos_ref, n;
        int unsigned span;
        longint      clon, clat;
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 2))
            0: span = $urandom_range(1, 1000);
            1: span = $urandom_range(1000, 1000000);
            default: span = $urandom_range(1000000, 100000000);
        endcase
        clon = longint'($urandom_range(0, 3400000000)) - 1700000000;
        clat = longint'($urandom_range(0, 1600000000)) - 800000000;
        case ($urandom_range(0, 19))
            0: cos_ref = 0;
            1: cos_ref = $urandom_range(65537, 131071);
            2: cos_ref = 65536;
            default: cos_ref = $urandom_range(1, 65536);
        endcase
        if (kind <= 6) begin
            holes = $urandom_range(0, 2);
            add_ring(clon, clat, span, $urandom_range(3, 8), cos_ref, 1'b1, holes == 0);
            for (int h = 0; h < holes; h++)
                add_ring(clon, clat, span / 4 + 1, $urandom_range(3, 6), cos_ref, 1'b1,
                         h == holes - 1);
        end else if (kind == 7) begin
            // raw bit patterns, out-of-range values included
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_row(longint'($urandom()), longint'($urandom()), $urandom(),
                        $urandom_range(0, 1), i == n - 1);
        end else if (kind == 8) begin
            // short ring, unclosed ring, or polygon end without ring end
            case ($urandom_range(0, 2))
                0: add_ring(clon, clat, span, $urandom_range(1, 2), cos_ref, 1'b1, 1'b1);
                1: add_ring(clon, clat, span, $urandom_range(4, 7), cos_ref, 1'b0, 1'b1);
                default: begin
                    add_ring(clon, clat, span, $urandom_range(3, 6), cos_ref, 1'b1, 1'b0);
                    add_ring(clon, clat, span / 2 + 1, $urandom_range(3, 6), cos_ref,
                             1'b1, 1'b1);
                    rows[$].v.ring_last = 1'b0;
                end
            endcase
        end else begin
            // collinear ring, zero cross sum
            n = $urandom_range(4, 7);
            for (int i = 0; i < n; i++)
                add_row(clon + i * 100, clat + i * 50, cos_ref, i == n - 1, i == n - 1);
        end
    endtask

    // Offer one vertex, wait for its transaction, record what it predicts
    bit send_burst = 1'b0;
    task automatic send_vertex(input t_row r);
        int       gap;
        bit       has;
        t_summary res;
        if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {r.v.cos_ref, r.v.lat, r.v.lon};
        i_s_tuser <= r.v.ring_last;
        i_s_tlast <= r.v.poly_last;
        do @(posedge i_clk); while (!o_s_tready);
        vertices_sent++;
        shoelace_step(r.v, has, res);
        if (has) begin
            summaries_due.push_back(r.typed ? r.want : res);
            polygons_done++;
        end
    endtask

    task automatic send_rows();
        while (rows.size() != 0) send_vertex(rows.pop_front());
    endtask

    // Stimulus
    initial begin
        clear_shadow();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pole, short, zero area, negative net, extremes
        add_row(0, 0, 0, 0, 0);
        add_row(10, 0, 0, 0, 0);
        add_row(0, 10, 0, 0, 0);
        add_row(0, 0, 0, 1, 1);
        rows[$].typed = 1'b1;
        rows[$].want.status = ST_POLE;
        add_row(0, 0, 65536, 0, 0);
        add_row(10, 0, 65536, 0, 0);
        add_error_row(0, 0, ST_SHORT);
        for (int i = 0; i < 3; i++) add_row(5, 5, 65536, 0, 0);
        add_error_row(5, 5, ST_ZERO);
        add_row(0, 0, 65536, 0, 0);
        add_row(10, 0, 65536, 0, 0);
        add_row(0, 10, 65536, 0, 0);
        add_row(0, 0, 65536, 1, 0);
        add_row(0, 0, 65536, 0, 0);
        add_row(1000, 0, 65536, 0, 0);
        add_row(0, 1000, 65536, 0, 0);
        add_error_row(0, 0, ST_NONPOS);
        add_row(-1800000000, -900000000, 65536, 0, 0);
        add_row(1800000000, -900000000, 65536, 0, 0);
        add_row(1800000000, 900000000, 65536, 0, 0);
        add_row(-1800000000, -900000000, 65536, 1, 1);
        send_rows();

        // Random polygons; one pause until everything has drained
        while (vertices_sent < 445) begin
            if (polygons_done == 40) begin
                i_s_tvalid <= 1'b0;
                @(negedge i_clk);
                while (summaries_due.size() != 0) @(negedge i_clk);
                @(posedge i_clk);
            end
            add_random_polygon();
            send_rows();
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow for the polygon-end latency
        while (summaries_due.size() != 0) @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
        $display("Covered %0d vertices in %0d polygons, %0d summaries checked,",
                 vertices_sent, polygons_done, summaries_seen);
        $display("including error statuses, holes, raw bit patterns and back-pressure.");
        if (errors == 0 && summaries_due.size() == 0) begin
            $display("polygon_area_centroid_shoelace verification clean");
        end else begin
            $display("polygon_area_centroid_shoelace verification failed");
        end
        $finish;
    end

    // Receiver: random stalls, bursts, and one long hold-off
    initial begin
        int  wait_cycles;
        bit  recv_burst;
        bit  held;
        recv_burst = 1'b0;
        held = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
            wait_cycles = recv_burst ? 0 : $urandom_range(0, 10);
            if (!held && summaries_seen == 10) begin
                held = 1'b1;
                wait_cycles = 4000;
            end
            if (wait_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Result check against the oldest expected summary
    always @(posedge i_clk) begin
        t_summary want;
        t_summary got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            summaries_seen++;
            got.area = o_m_tdata[48:0];
            got.cent_x = o_m_tdata[74:49];
            got.cent_y = o_m_tdata[100:75];
            got.status = t_status'(o_m_tdata[103:101]);
            if (summaries_due.size() == 0) begin
                $error("unexpected summary transaction");
                errors++;
            end else begin
                want = summaries_due.pop_front();
                if (got.area !== want.area) begin
                    $error("area_m2 expected %0d got %0d", want.area, got.area);
                    errors++;
                end
                if (got.cent_x !== want.cent_x) begin
                    $error("centroid_x_m expected %0d got %0d", want.cent_x, got.cent_x);
                    errors++;
                end
                if (got.cent_y !== want.cent_y) begin
                    $error("centroid_y_m expected %0d got %0d", want.cent_y, got.cent_y);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #20ms;
        $display("polygon_area_centroid_shoelace verification failed");
        $finish;
    end

endmodule
`default_nettype wire
